// ===== sv/rqs_pkg.sv =====
`timescale 1ns / 1ps
package rqs_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W        = 6;
  localparam int TIME_W      = 20;
  localparam int HELD_W      = 7;
  localparam int POL_W       = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int ENTRY_W     = ID_W + TIME_W;

  localparam int IN_FIELDS_W  = ID_W + TIME_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_TUSER_W   = 1;
  localparam int OUT_FIELDS_W = ID_W + TIME_W + 3 + HELD_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [TIME_W-1:0] QUANTUM_RST = TIME_W'(500);
  localparam logic [TIME_W-1:0] PREEMPT_RST = TIME_W'(100);

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_PREEMPT = CFG_IDX_W'(2);

  localparam logic MODE_INSERT   = 1'b0;
  localparam logic MODE_DISPATCH = 1'b1;

  typedef enum logic [POL_W-1:0] {
    POL_FIFO = 2'd0,
    POL_RR   = 2'd1,
    POL_SJF  = 2'd2,
    POL_PSJF = 2'd3
  } policy_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_INS_CMP,
    ST_INS_WR,
    ST_DSP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] rem;
  } entry_t;

  typedef struct packed {
    logic [ID_W-1:0]   gid;
    logic [TIME_W-1:0] slice;
    logic              fin;
    logic              empty;
    logic              full;
  } result_t;

  typedef struct packed {
    logic              lt;
    logic [TIME_W-1:0] diff;
  } cmp_res_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
    if (ptr == PTR_W'(QUEUE_DEPTH - 1)) return '0;
    return ptr + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] ptr);
    if (ptr == '0) return PTR_W'(QUEUE_DEPTH - 1);
    return ptr - PTR_W'(1);
  endfunction

endpackage

// ===== sv/rqs_ram.sv =====
`timescale 1ns / 1ps
module rqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/rqs_cmp_unit.sv =====
`timescale 1ns / 1ps
module rqs_cmp_unit (
  input  logic [rqs_pkg::TIME_W-1:0] opnd,
  input  logic [rqs_pkg::TIME_W-1:0] rem,
  output rqs_pkg::cmp_res_t          res
);
  import rqs_pkg::*;

  // shared compare and subtract: opnd < rem, rem - opnd
  always_comb begin
    res.lt   = (opnd < rem);
    res.diff = rem - opnd;
  end

endmodule

// ===== sv/ready_queue_cpu_scheduler.sv =====
`timescale 1ns / 1ps
// path to out_tvalid: a fifo/round-robin insert, a full insert, an insert into an empty queue and
// an empty dispatch go from decode to done, a dispatch passes decode, dispatch and done; a sorted
// insert walks one queued entry per cycle from the tail, then writes the item and goes to done
// no new item is taken before the last one is through: in_tready is high only while the sequencer idles;
// the entry walk is bound by the single ram read port, and an untaken result holds the done state
// reset: rst_n synchronous active low, empties the queue, loads fifo, quantum 500, unit 100
module ready_queue_cpu_scheduler (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [rqs_pkg::IN_TDATA_W-1:0]     in_tdata,   // job_id, burst_time, zero pad
  input  logic [rqs_pkg::IN_TUSER_W-1:0]     in_tuser,   // mode
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // granted_id, slice_length, job_finished, queue_empty, queue_full, entries_held, zero pad
  output logic [rqs_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                               cfg_we,
  input  logic [rqs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rqs_pkg::TIME_W-1:0]         cfg_wdata
);
  import rqs_pkg::*;

  state_t state_r, state_nxt;

  policy_t           policy_r;
  logic [TIME_W-1:0] quantum_r;
  logic [TIME_W-1:0] preempt_r;

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [PTR_W-1:0] p_r, p_nxt;

  logic              item_mode_r;
  logic [ID_W-1:0]   item_id_r;
  logic [TIME_W-1:0] item_burst_r;

  result_t res_r, res_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_FIELDS_W-1:0] out_data_r, out_data_nxt;

  logic             mem_we;
  logic [PTR_W-1:0] mem_waddr;
  logic [PTR_W-1:0] mem_raddr;
  entry_t           mem_wdata;
  entry_t           mem_rdata;

  logic [TIME_W-1:0] cmp_opnd;
  cmp_res_t          cmp_res;

  logic sorted;
  logic in_xfer;

  assign sorted  = (policy_r == POL_SJF) || (policy_r == POL_PSJF);
  assign in_xfer = in_tvalid && in_tready;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, out_data_r};

  rqs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rqs_cmp_unit u_cmp (
    .opnd (cmp_opnd),
    .rem  (mem_rdata.rem),
    .res  (cmp_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r  <= POL_FIFO;
      quantum_r <= QUANTUM_RST;
      preempt_r <= PREEMPT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLICY:  policy_r  <= policy_t'(cfg_wdata[POL_W-1:0]);
        CFG_QUANTUM: quantum_r <= cfg_wdata;
        CFG_PREEMPT: preempt_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    p_r        <= p_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    if (in_xfer) begin
      item_mode_r  <= in_tuser[0];
      item_id_r    <= in_tdata[ID_W-1:0];
      item_burst_r <= in_tdata[ID_W +: TIME_W];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    p_nxt         = p_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = p_r;
    mem_wdata     = '{id: item_id_r, rem: item_burst_r};
    mem_raddr     = head_r;
    cmp_opnd      = item_burst_r;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) state_nxt = ST_DECODE;
      end

      ST_DECODE: begin
        res_nxt = '0;
        if (item_mode_r == MODE_INSERT) begin
          if (count_r >= CNT_W'(QUEUE_DEPTH)) begin
            res_nxt.full = 1'b1;
            state_nxt    = ST_DONE;
          end else if (!sorted || count_r == '0) begin
            mem_we    = 1'b1;
            mem_waddr = tail_r;
            tail_nxt  = ptr_inc(tail_r);
            count_nxt = count_r + CNT_W'(1);
            state_nxt = ST_DONE;
          end else begin
            // walk back from the tail, shifting larger entries up by one
            p_nxt     = tail_r;
            pos_nxt   = count_r;
            mem_raddr = ptr_dec(tail_r);
            state_nxt = ST_INS_CMP;
          end
        end else if (count_r == '0) begin
          res_nxt.empty = 1'b1;
          state_nxt     = ST_DONE;
        end else begin
          mem_raddr = head_r;
          state_nxt = ST_DSP;
        end
      end

      ST_INS_CMP: begin
        cmp_opnd = item_burst_r;
        if (cmp_res.lt) begin
          mem_we    = 1'b1;
          mem_waddr = p_r;
          mem_wdata = mem_rdata;
          p_nxt     = ptr_dec(p_r);
          pos_nxt   = pos_r - CNT_W'(1);
          mem_raddr = ptr_dec(ptr_dec(p_r));
          if (pos_r == CNT_W'(1)) state_nxt = ST_INS_WR;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = p_r;
          tail_nxt  = ptr_inc(tail_r);
          count_nxt = count_r + CNT_W'(1);
          state_nxt = ST_DONE;
        end
      end

      ST_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = p_r;
        tail_nxt  = ptr_inc(tail_r);
        count_nxt = count_r + CNT_W'(1);
        state_nxt = ST_DONE;
      end

      ST_DSP: begin
        res_nxt.gid = mem_rdata.id;
        cmp_opnd    = (policy_r == POL_RR) ? quantum_r : preempt_r;
        state_nxt   = ST_DONE;
        case (policy_r)
          POL_RR: begin
            if (cmp_res.lt) begin
              // unfinished: back of the line with the slice taken off
              res_nxt.slice = quantum_r;
              mem_we        = 1'b1;
              mem_waddr     = tail_r;
              mem_wdata     = '{id: mem_rdata.id, rem: cmp_res.diff};
              head_nxt      = ptr_inc(head_r);
              tail_nxt      = ptr_inc(tail_r);
            end else begin
              res_nxt.slice = mem_rdata.rem;
              res_nxt.fin   = 1'b1;
              head_nxt      = ptr_inc(head_r);
              count_nxt     = count_r - CNT_W'(1);
            end
          end
          POL_PSJF: begin
            if (cmp_res.lt) begin
              // unfinished: stays at the head
              res_nxt.slice = preempt_r;
              mem_we        = 1'b1;
              mem_waddr     = head_r;
              mem_wdata     = '{id: mem_rdata.id, rem: cmp_res.diff};
            end else begin
              res_nxt.slice = mem_rdata.rem;
              res_nxt.fin   = 1'b1;
              head_nxt      = ptr_inc(head_r);
              count_nxt     = count_r - CNT_W'(1);
            end
          end
          default: begin
            res_nxt.slice = mem_rdata.rem;
            res_nxt.fin   = 1'b1;
            head_nxt      = ptr_inc(head_r);
            count_nxt     = count_r - CNT_W'(1);
          end
        endcase
      end

      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {HELD_W'(count_r), res_r.full, res_r.empty, res_r.fin,
                           res_r.slice, res_r.gid};
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // tail must always sit count entries after the head
  logic [PTR_W:0] tail_chk_sum;
  logic [PTR_W:0] tail_chk;
  assign tail_chk_sum = {1'b0, head_r} + (PTR_W+1)'(count_r);
  assign tail_chk     = (tail_chk_sum >= (PTR_W+1)'(QUEUE_DEPTH))
                      ? tail_chk_sum - (PTR_W+1)'(QUEUE_DEPTH) : tail_chk_sum;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_tail_track: assert property (@(posedge clk) disable iff (!rst_n)
    tail_chk[PTR_W-1:0] == tail_r)
    else $error("tail pointer out of step with head and count");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r[ID_W+TIME_W+1] && out_data_r[ID_W+TIME_W+2]))
    else $error("empty and full flagged together");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && (!out_valid_r || out_tready)) |=> state_r == ST_IDLE && out_valid_r)
    else $error("result not presented after done");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import rqs_pkg::*;

  localparam int SLICE_LSB   = ID_W;
  localparam int FIN_BIT     = ID_W + TIME_W;
  localparam int EMPTY_BIT   = FIN_BIT + 1;
  localparam int FULL_BIT    = FIN_BIT + 2;
  localparam int HELD_LSB    = FIN_BIT + 3;
  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD   = 120;
  localparam int SETTLE_WAIT = 80;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 64;

  typedef struct packed {
    logic [ID_W-1:0]   gid;
    logic [TIME_W-1:0] slice;
    logic              fin;
    logic              empty;
    logic              full;
    logic [HELD_W-1:0] held;
  } grant_t;

  typedef enum bit {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic                  mode;
    logic [ID_W-1:0]       id;
    logic [TIME_W-1:0]     val;
    logic [CFG_IDX_W-1:0]  reg_idx;
    bit                    typed;
    grant_t                want;
  } plan_row_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // job_id, burst_time, zero pad
  logic [IN_TUSER_W-1:0]  in_tuser = '0;   // mode
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // granted_id, slice_length, job_finished, queue_empty, queue_full, entries_held, zero pad
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [TIME_W-1:0]      cfg_wdata = '0;

  // predicted scheduler state
  logic [ID_W-1:0]   ready_id  [QUEUE_DEPTH];
  logic [TIME_W-1:0] ready_rem [QUEUE_DEPTH];
  int                ready_cnt  = 0;
  policy_t           cur_pol    = POL_FIFO;
  logic [TIME_W-1:0] rr_quantum = QUANTUM_RST;
  logic [TIME_W-1:0] psjf_unit  = PREEMPT_RST;

  grant_t grants_due[$];
  int     err_cnt = 0;
  int     n_ins = 0, n_full = 0, n_disp = 0, n_empty = 0, n_fin = 0;
  bit     stall_req = 1'b0;
  bit     no_idle = 1'b0;

  ready_queue_cpu_scheduler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // take the head off; keep puts it back at the tail
  function automatic void drop_head(input bit keep);
    logic [ID_W-1:0]   hid;
    logic [TIME_W-1:0] hrem;
    hid  = ready_id[0];
    hrem = ready_rem[0];
    for (int i = 1; i < ready_cnt; i++) begin
      ready_id[i-1]  = ready_id[i];
      ready_rem[i-1] = ready_rem[i];
    end
    if (keep) begin
      ready_id[ready_cnt-1]  = hid;
      ready_rem[ready_cnt-1] = hrem;
    end else begin
      ready_cnt--;
    end
  endfunction

  function automatic grant_t schedule_item(input logic m, input logic [ID_W-1:0] id,
                                           input logic [TIME_W-1:0] burst);
    grant_t            g;
    int                pos;
    logic [TIME_W-1:0] hrem;
    g = '0;
    if (m == MODE_INSERT) begin
      n_ins++;
      if (ready_cnt >= QUEUE_DEPTH) begin
        g.full = 1'b1;
        n_full++;
      end else begin
        pos = ready_cnt;
        // sorted policies walk back from the tail and go in after the first entry with equal or smaller time
        if (cur_pol == POL_SJF || cur_pol == POL_PSJF) begin
          while (pos > 0 && burst < ready_rem[pos-1]) begin
            ready_id[pos]  = ready_id[pos-1];
            ready_rem[pos] = ready_rem[pos-1];
            pos--;
          end
        end
        ready_id[pos]  = id;
        ready_rem[pos] = burst;
        ready_cnt++;
      end
    end else begin
      n_disp++;
      if (ready_cnt == 0) begin
        g.empty = 1'b1;
        n_empty++;
      end else begin
        hrem  = ready_rem[0];
        g.gid = ready_id[0];
        case (cur_pol)
          POL_FIFO, POL_SJF: begin
            g.slice = hrem;
            g.fin   = 1'b1;
            drop_head(1'b0);
          end
          POL_RR: begin
            if (hrem > rr_quantum) begin
              g.slice      = rr_quantum;
              ready_rem[0] = hrem - rr_quantum;
              drop_head(1'b1);
            end else begin
              g.slice = hrem;
              g.fin   = 1'b1;
              drop_head(1'b0);
            end
          end
          default: begin
            g.slice      = (psjf_unit < hrem) ? psjf_unit : hrem;
            ready_rem[0] = hrem - g.slice;
            if (ready_rem[0] == '0) begin
              g.fin = 1'b1;
              drop_head(1'b0);
            end
          end
        endcase
      end
    end
    if (g.fin) n_fin++;
    g.held = HELD_W'(ready_cnt);
    return g;
  endfunction

  function automatic grant_t grant(input int gid, input int slice, input bit fin,
                                   input bit empty, input bit full, input int held);
    grant_t g;
    g.gid   = ID_W'(gid);
    g.slice = TIME_W'(slice);
    g.fin   = fin;
    g.empty = empty;
    g.full  = full;
    g.held  = HELD_W'(held);
    return g;
  endfunction

  function automatic plan_row_t item(input logic m, input int id, input int val);
    plan_row_t r;
    r.kind    = ROW_ITEM;
    r.mode    = m;
    r.id      = ID_W'(id);
    r.val     = TIME_W'(val);
    r.reg_idx = CFG_POLICY;
    r.typed   = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  function automatic plan_row_t item_x(input logic m, input int id, input int val,
                                       input grant_t want);
    plan_row_t r;
    r       = item(m, id, val);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic plan_row_t reg_wr(input logic [CFG_IDX_W-1:0] idx, input int val);
    plan_row_t r;
    r         = item(MODE_INSERT, 0, val);
    r.kind    = ROW_REG;
    r.reg_idx = idx;
    return r;
  endfunction

  function automatic logic [TIME_W-1:0] pick_slice(input int k);
    case (k % 5)
      0:       return TIME_W'(1);
      1:       return '1;
      2:       return '0;
      3:       return TIME_W'($urandom);
      default: return TIME_W'($urandom_range(1, 3000));
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_burst();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r < 3) return TIME_W'($urandom);
    return TIME_W'($urandom_range(1, 1500));
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  task automatic send_item(input logic m, input logic [ID_W-1:0] id,
                           input logic [TIME_W-1:0] burst);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= IN_TDATA_W'({burst, id});
    do @(posedge clk); while (in_tready !== 1'b1);
    grants_due.push_back(schedule_item(m, id, burst));
  endtask

  // leaves cfg_we high; the caller lowers it once its writes are done
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_POLICY:  cur_pol = policy_t'(val[POL_W-1:0]);
      CFG_QUANTUM: rr_quantum = val;
      CFG_PREEMPT: psjf_unit = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (grants_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // result side; the wait at the loop head lengthens each hold
  initial begin
    forever begin
      @(posedge clk);
      if (stall_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        stall_req = 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 8)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    grant_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (grants_due.size() == 0) begin
        $error("result transfer with no item outstanding: tdata %h", out_tdata);
        err_cnt++;
      end else begin
        want = grants_due.pop_front();
        check_field("granted_id", want.gid, out_tdata[ID_W-1:0]);
        check_field("slice_length", want.slice, out_tdata[SLICE_LSB +: TIME_W]);
        check_field("job_finished", want.fin, out_tdata[FIN_BIT]);
        check_field("queue_empty", want.empty, out_tdata[EMPTY_BIT]);
        check_field("queue_full", want.full, out_tdata[FULL_BIT]);
        check_field("entries_held", want.held, out_tdata[HELD_LSB +: HELD_W]);
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("no transfer for %0d cycles, %0d results outstanding",
                 quiet, grants_due.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    plan_row_t plan[$];
    plan_row_t r;
    bit        after_item;
    int        disp_pct;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: fifo, quantum 500, preempt unit 100
    plan.push_back(item_x(MODE_DISPATCH, 21, 'h55555, grant(0, 0, 0, 1, 0, 0)));
    plan.push_back(item_x(MODE_INSERT, 63, 'hFFFFF, grant(0, 0, 0, 0, 0, 1)));
    plan.push_back(item_x(MODE_INSERT, 0, 0, grant(0, 0, 0, 0, 0, 2)));
    plan.push_back(item_x(MODE_DISPATCH, 42, 'hAAAAA, grant(63, 'hFFFFF, 1, 0, 0, 1)));
    // zero burst finishes on first dispatch with nothing granted
    plan.push_back(item_x(MODE_DISPATCH, 0, 0, grant(0, 0, 1, 0, 0, 0)));
    plan.push_back(reg_wr(CFG_POLICY, POL_RR));
    plan.push_back(item_x(MODE_INSERT, 5, 1200, grant(0, 0, 0, 0, 0, 1)));
    plan.push_back(item_x(MODE_INSERT, 6, 500, grant(0, 0, 0, 0, 0, 2)));
    plan.push_back(item_x(MODE_DISPATCH, 0, 0, grant(5, 500, 0, 0, 0, 2)));
    plan.push_back(item_x(MODE_DISPATCH, 0, 0, grant(6, 500, 1, 0, 0, 1)));
    plan.push_back(item_x(MODE_DISPATCH, 0, 0, grant(5, 500, 0, 0, 0, 1)));
    plan.push_back(item_x(MODE_DISPATCH, 0, 0, grant(5, 200, 1, 0, 0, 0)));
    // zero quantum: nothing granted, job rotates
    plan.push_back(reg_wr(CFG_QUANTUM, 0));
    plan.push_back(item_x(MODE_INSERT, 7, 3, grant(0, 0, 0, 0, 0, 1)));
    plan.push_back(item_x(MODE_DISPATCH, 0, 0, grant(7, 0, 0, 0, 0, 1)));
    // sorted insert keeps equal times in arrival order
    plan.push_back(reg_wr(CFG_POLICY, POL_PSJF));
    plan.push_back(item(MODE_INSERT, 8, 250));
    plan.push_back(item(MODE_INSERT, 9, 3));
    plan.push_back(item_x(MODE_DISPATCH, 0, 0, grant(7, 3, 1, 0, 0, 2)));
    plan.push_back(item_x(MODE_DISPATCH, 0, 0, grant(9, 3, 1, 0, 0, 1)));
    plan.push_back(item_x(MODE_DISPATCH, 0, 0, grant(8, 100, 0, 0, 0, 1)));
    plan.push_back(reg_wr(CFG_PREEMPT, 0));
    plan.push_back(item_x(MODE_DISPATCH, 0, 0, grant(8, 0, 0, 0, 0, 1)));
    plan.push_back(reg_wr(CFG_PREEMPT, 'hFFFFF));
    plan.push_back(item_x(MODE_DISPATCH, 0, 0, grant(8, 150, 1, 0, 0, 0)));
    plan.push_back(reg_wr(CFG_POLICY, POL_SJF));
    plan.push_back(item(MODE_INSERT, 10, 40));
    plan.push_back(item(MODE_INSERT, 11, 20));
    plan.push_back(item(MODE_DISPATCH, 0, 0));
    plan.push_back(item(MODE_DISPATCH, 0, 0));

    after_item = 1'b0;
    foreach (plan[i]) begin
      r = plan[i];
      if (r.kind == ROW_REG) begin
        if (after_item) drain();
        write_reg(r.reg_idx, r.val);
        after_item = 1'b0;
      end else begin
        cfg_we <= 1'b0;
        send_item(r.mode, r.id, r.val);
        if (r.typed) grants_due[$] = r.want;
        after_item = 1'b1;
      end
    end

    // fill the queue under sjf, then push against the full queue and dispatch from it
    drain();
    write_reg(CFG_POLICY, {18'($urandom), POL_SJF});
    cfg_we <= 1'b0;
    while (ready_cnt < QUEUE_DEPTH)
      send_item(MODE_INSERT, ID_W'($urandom), pick_burst());
    repeat (4) send_item(MODE_INSERT, ID_W'($urandom), pick_burst());
    repeat (20) send_item(MODE_DISPATCH, ID_W'($urandom), TIME_W'($urandom));

    for (int p = 0; p < PHASES; p++) begin
      drain();
      no_idle = (p == PHASES - 1);
      write_reg(CFG_POLICY, {18'($urandom), POL_W'(p % 4)});
      write_reg(CFG_QUANTUM, pick_slice(p));
      write_reg(CFG_PREEMPT, pick_slice(p + 2));
      cfg_we <= 1'b0;
      disp_pct = (p % 3 == 0) ? 35 : (p % 3 == 1) ? 50 : 65;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == 10) stall_req = 1'b1;
        if ($urandom_range(0, 99) < disp_pct)
          send_item(MODE_DISPATCH, ID_W'($urandom), TIME_W'($urandom));
        else
          send_item(MODE_INSERT, ID_W'($urandom), pick_burst());
      end
    end

    drain();
    repeat (SETTLE_WAIT) @(posedge clk);
    if (grants_due.size() != 0) begin
      $error("%0d results never arrived", grants_due.size());
      err_cnt++;
    end

    $display("ran %0d inserts (%0d turned away by a full queue) and %0d dispatches",
             n_ins, n_full, n_disp);
    $display("of the dispatches %0d found the queue empty and %0d completed a job",
             n_empty, n_fin);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/rqs_pkg.sv
sv/rqs_ram.sv
sv/rqs_cmp_unit.sv
sv/ready_queue_cpu_scheduler.sv
tb/sv/tb_top.sv
